FILE: rtl/c_comment_extractor_top_macros.svh
// Assertion helpers for the comment extractor.
// All macros expect signals named clk and rst_n in the using scope.
`ifndef C_COMMENT_EXTRACTOR_TOP_MACROS_SVH
`define C_COMMENT_EXTRACTOR_TOP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CCE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds while its channel is stalled.
`define CCE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

FILE: rtl/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types and character codes for the comment extractor.
// ----------------------------------------------------------------------------
package cce_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Most bytes one request can produce
    localparam int RUN_MAX = 4;

    typedef struct packed {
        logic [7:0] prev_char;
        logic       in_block;
        logic       in_line;
        logic       in_dquote;
        logic       in_squote;
        logic       line_had;
        logic       odd_dquote;
        logic       odd_squote;
    } cce_state_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } cce_run_t;

endpackage

FILE: rtl/c_comment_extractor_top.sv
// ----------------------------------------------------------------------------
// c_comment_extractor_top
// Byte-serial C comment extractor: emits comment bytes and their newlines.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_ready  | in_char, end_of_input
//  out     | source    | out_valid / out_ready| out_char, last_of_run
//
// A request is registered in the input register, evaluated combinationally
// and its 0 to 4 result bytes are loaded into a run buffer that drains one
// byte per cycle while out_ready is high. Throughput is one request per cycle
// while each request yields at most one byte and out_ready is high; a longer
// run holds the input until its last byte leaves the run buffer.
// Reset clears all comment and quote state and empties both stages.
module c_comment_extractor_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);
    import cce_pkg::*;

    logic                    s1_valid_reg;
    logic [7:0]              s1_char_reg;
    logic                    s1_eoi_reg;
    cce_state_t              state_reg;
    cce_state_t              state_next;
    cce_run_t                run_next;
    logic [RUN_MAX-1:0][7:0] run_bytes_reg;
    logic [2:0]              run_left_reg;
    logic [1:0]              run_idx_reg;
    logic                    load_ok;
    logic                    load;
    logic                    out_fire;

    // run buffer may take a new run once its last byte leaves
    assign out_valid   = (run_left_reg != 3'd0);
    assign out_char    = run_bytes_reg[run_idx_reg];
    assign last_of_run = (run_left_reg == 3'd1);
    assign out_fire    = out_valid && out_ready;
    assign load_ok     = !out_valid || (last_of_run && out_ready);
    assign load        = s1_valid_reg && load_ok;
    assign in_ready    = !s1_valid_reg || load_ok;

    cce_step u_step
    (
        .st           (state_reg),
        .in_char      (s1_char_reg),
        .end_of_input (s1_eoi_reg),
        .st_next      (state_next),
        .run          (run_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= in_char;
            s1_eoi_reg  <= end_of_input;
        end
    end

    // extractor state advances as each request is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    // run buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_left_reg <= 3'd0;
            run_idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            run_left_reg <= run_next.cnt;
            run_idx_reg  <= 2'd0;
        end
        else if (out_fire)
        begin
            run_left_reg <= run_left_reg - 3'd1;
            run_idx_reg  <= run_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_bytes_reg <= run_next.bytes;
        end
    end

endmodule

FILE: rtl/cce_step.sv
// ----------------------------------------------------------------------------
// cce_step
// Next-state and emitted byte run for one source byte or end marker.
// ----------------------------------------------------------------------------
module cce_step
(
    input  cce_pkg::cce_state_t st,
    input  logic [7:0]          in_char,
    input  logic                end_of_input,
    output cce_pkg::cce_state_t st_next,
    output cce_pkg::cce_run_t   run
);
    import cce_pkg::*;

    always_comb
    begin
        logic       any_comment;
        logic       any_quote;
        logic       opener;
        logic [7:0] prev;
        logic [2:0] cnt;
        logic [RUN_MAX-1:0][7:0] bytes;

        prev        = st.prev_char;
        any_comment = st.in_line | st.in_block;
        any_quote   = st.in_squote | st.in_dquote;
        opener      = 1'b0;
        cnt         = 3'd0;
        bytes       = '0;
        st_next     = st;

        if (end_of_input)
        begin
            // final newline, back to reset state
            bytes[0] = CH_NL;
            cnt      = 3'd1;
            st_next  = '0;
        end
        else
        begin
            priority if (in_char == CH_NL)
            begin
                if (!st.in_block)
                begin
                    st_next.in_line   = 1'b0;
                    st_next.in_squote = 1'b0;
                    st_next.in_dquote = 1'b0;
                end
                if (st.line_had)
                begin
                    bytes[cnt[1:0]]  = in_char;
                    cnt              = cnt + 3'd1;
                    st_next.line_had = 1'b0;
                end
            end
            else if (prev == CH_SLASH && (in_char == CH_SLASH || in_char == CH_STAR))
            begin
                // open a comment unless hidden by a quote or already in a comment, odd marks override
                if (!any_comment && !any_quote)
                begin
                    opener = 1'b1;
                end
                else if (st.odd_squote || st.odd_dquote)
                begin
                    opener = 1'b1;
                    if (st.odd_squote)
                        st_next.in_squote = 1'b0;
                    if (st.odd_dquote)
                        st_next.in_dquote = 1'b0;
                end
                if (opener)
                begin
                    bytes[cnt[1:0]]  = prev;
                    cnt              = cnt + 3'd1;
                    st_next.line_had = 1'b1;
                    if (in_char == CH_SLASH)
                        st_next.in_line = 1'b1;
                    else
                        st_next.in_block = 1'b1;
                end
            end
            else if (prev == CH_STAR && in_char == CH_SLASH)
            begin
                if (st.in_block)
                begin
                    bytes[cnt[1:0]]  = prev;
                    cnt              = cnt + 3'd1;
                    bytes[cnt[1:0]]  = in_char;
                    cnt              = cnt + 3'd1;
                    st_next.in_block = 1'b0;
                    st_next.line_had = 1'b1;
                    if (st.odd_squote)
                        st_next.in_squote = 1'b1;
                    if (st.odd_dquote)
                        st_next.in_dquote = 1'b1;
                end
                if (st.in_line)
                begin
                    bytes[cnt[1:0]] = prev;
                    cnt             = cnt + 3'd1;
                end
            end
            else if (in_char == CH_DQUOTE)
            begin
                if (st.in_dquote)
                begin
                    st_next.in_dquote  = 1'b0;
                    st_next.odd_dquote = 1'b0;
                end
                else if (!any_comment && !any_quote)
                begin
                    st_next.in_dquote  = 1'b1;
                    st_next.odd_dquote = 1'b1;
                end
            end
            else if (in_char == CH_SQUOTE)
            begin
                if (st.in_squote)
                begin
                    st_next.in_squote  = 1'b0;
                    st_next.odd_squote = 1'b0;
                end
                else if (!any_comment && !any_quote)
                begin
                    st_next.in_squote  = 1'b1;
                    st_next.odd_squote = 1'b1;
                end
            end
            else
            begin
                opener = 1'b0;
            end

            // pass the byte itself while inside a comment
            if (st_next.in_block || st_next.in_line)
            begin
                bytes[cnt[1:0]] = in_char;
                cnt             = cnt + 3'd1;
            end
            st_next.prev_char = in_char;
        end

        run.bytes = bytes;
        run.cnt   = cnt;
    end

endmodule

FILE: rtl/cce_checker.sv
// ----------------------------------------------------------------------------
// cce_checker
// Port-level checks for the comment extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "c_comment_extractor_top_macros.svh"

module cce_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] in_char,
    input logic       end_of_input,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_of_run
);

    // input stalls only behind a pending result
    `CCE_ASSERT(a_stall_has_cause, !in_ready |-> out_valid, "input stalled with no result pending")

    // a run that is not finished keeps going
    `CCE_ASSERT(a_run_continues, (out_valid && out_ready && !last_of_run) |=> out_valid, "run cut short")

    // a waiting request keeps valid and its payload
    `CCE_ASSERT_HOLD(a_in_req_hold, in_valid, in_ready, ({in_valid, in_char, end_of_input}), "input request changed while stalled")

    // a stalled result holds its byte and marker
    `CCE_ASSERT_HOLD(a_out_char_hold, out_valid, out_ready, out_char, "out_char changed while stalled")
    `CCE_ASSERT_HOLD(a_out_last_hold, out_valid, out_ready, last_of_run, "last_of_run changed while stalled")

endmodule

bind c_comment_extractor_top cce_checker u_cce_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .last_of_run  (last_of_run)
);
